>>> rtl/rfmt_pkg.sv
// package for the reference-counted feature mask table
// holds command and status codes, field widths, control state and table update types
// no dependencies
package rfmt_pkg;

    localparam int CMD_W    = 3;
    localparam int SRC_ID_W = 16;
    localparam int FEAT_W   = 64;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_DIRECT = 3'd0,
        CMD_UPDATE     = 3'd1,
        CMD_BIND       = 3'd2,
        CMD_UNBIND     = 3'd3,
        CMD_REMOVE     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED   = 2'd0,
        ST_NOOP      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // id table update request
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cam_upd;

endpackage

>>> rtl/rfmt_if.sv
// valid/ready channel interfaces for commands and results
// depends on rfmt_pkg for the field widths
interface rfmt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [rfmt_pkg::CMD_W-1:0]    cmd;
    logic [rfmt_pkg::SRC_ID_W-1:0] source_id;
    logic [rfmt_pkg::FEAT_W-1:0]   feature_bits_in;

    modport source (output valid, cmd, source_id, feature_bits_in, input ready);
    modport sink   (input valid, cmd, source_id, feature_bits_in, output ready);
endinterface

interface rfmt_res_if;
    logic                         valid;
    logic                         ready;
    logic [rfmt_pkg::FEAT_W-1:0]   union_mask;
    logic                         mask_changed;
    logic [rfmt_pkg::STATUS_W-1:0] status;

    modport source (output valid, union_mask, mask_changed, status, input ready);
    modport sink   (input valid, union_mask, mask_changed, status, output ready);
endinterface

>>> rtl/rfmt_id_cam.sv
// id table: valid flags and source ids with parallel match and free-slot search
// depends on rfmt_pkg for the update struct
module rfmt_id_cam #(
    parameter int MAX_SOURCES = 32,
    parameter int KEY_W       = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [KEY_W-1:0]               i_key,
    output logic                           o_hit,
    output logic [$clog2(MAX_SOURCES)-1:0] o_hit_idx,
    output logic                           o_free_ok,
    output logic [$clog2(MAX_SOURCES)-1:0] o_free_idx,
    input  rfmt_pkg::t_cam_upd             i_upd,
    input  logic [$clog2(MAX_SOURCES)-1:0] i_upd_idx,
    input  logic [KEY_W-1:0]               i_upd_key
);
    import rfmt_pkg::*;

    localparam int IDX_W = $clog2(MAX_SOURCES);

    logic [MAX_SOURCES-1:0] r_valid;
    logic [KEY_W-1:0]       r_key [MAX_SOURCES];

    // lowest match and lowest free slot
    always_comb begin
        o_hit      = 1'b0;
        o_hit_idx  = '0;
        o_free_ok  = 1'b0;
        o_free_idx = '0;
        for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                o_hit     = 1'b1;
                o_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                o_free_ok  = 1'b1;
                o_free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_upd.insert) begin
            r_valid[i_upd_idx] <= 1'b1;
        end else if (i_upd.remove) begin
            r_valid[i_upd_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.insert) begin
            r_key[i_upd_idx] <= i_upd_key;
        end
    end

endmodule

>>> rtl/rfmt_entry_ram.sv
// entry payload memory: mask, direct flag and binding count per slot
// one write port, one read port with registered data; no package use
module rfmt_entry_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rfmt_bit_users.sv
// per-bit user counters and the held union mask
// one counter lane per feature bit; no package use
module rfmt_bit_users #(
    parameter int FEATURE_BITS = 64,
    parameter int CNT_W        = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [FEATURE_BITS-1:0] i_removed,
    input  logic [FEATURE_BITS-1:0] i_added,
    output logic [FEATURE_BITS-1:0] o_held,
    output logic [FEATURE_BITS-1:0] o_held_next
);
    logic [CNT_W-1:0]        r_users [FEATURE_BITS];
    logic [CNT_W-1:0]        n_users [FEATURE_BITS];
    logic [FEATURE_BITS-1:0] r_held;

    always_comb begin
        for (int b = 0; b < FEATURE_BITS; b++) begin
            n_users[b] = r_users[b];
            if (i_en && i_removed[b] && (r_users[b] != '0)) begin
                n_users[b] = r_users[b] - CNT_W'(1);
            end else if (i_en && i_added[b]) begin
                n_users[b] = r_users[b] + CNT_W'(1);
            end
            o_held_next[b] = (n_users[b] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < FEATURE_BITS; b++) begin
                r_users[b] <= '0;
            end
            r_held <= '0;
        end else if (i_en) begin
            for (int b = 0; b < FEATURE_BITS; b++) begin
                r_users[b] <= n_users[b];
            end
            r_held <= o_held_next;
        end
    end

    assign o_held = r_held;

endmodule

>>> rtl/refcounted_feature_mask_table.sv
// top level of the reference-counted feature mask table
// depends on rfmt_pkg, rfmt_if, rfmt_id_cam, rfmt_entry_ram and rfmt_bit_users
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+-------------------------------------------
//  i_cmd    | in  | valid/ready | cmd, source_id, feature_bits_in
//  o_res    | out | valid/ready | union_mask, mask_changed, status
//
// a command goes through lookup in the id table plus entry memory read,
// then execute with memory write-back and counter update
// one command in flight; the next one is taken as soon as the block is idle,
// even while the last result still sits in the output register
// execute stalls while the output register holds an untaken result
// synchronous reset clears the valid flags, bit counters and union mask at
// once; no clearing pass, the block takes a command right after reset
module refcounted_feature_mask_table #(
    parameter int MAX_SOURCES      = 32,
    parameter int FEATURE_BITS     = 64,
    parameter int ID_WIDTH         = 16,
    parameter int BIND_COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfmt_cmd_if.sink   i_cmd,
    rfmt_res_if.source o_res
);
    import rfmt_pkg::*;

    localparam int IDX_W = $clog2(MAX_SOURCES);
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int KEY_W = (ID_WIDTH < SRC_ID_W) ? ID_WIDTH : SRC_ID_W;
    localparam int ENT_W = FEATURE_BITS + 1 + BIND_COUNT_WIDTH;

    // control
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_commit;

    // captured command
    logic [CMD_W-1:0]        r_cmd;
    logic [KEY_W-1:0]        r_id;
    logic [FEATURE_BITS-1:0] r_bits;
    logic                    r_hit;
    logic [IDX_W-1:0]        r_hit_idx;
    logic                    r_free_ok;
    logic [IDX_W-1:0]        r_free_idx;

    // lookup
    logic [KEY_W-1:0] w_key;
    logic             w_hit;
    logic [IDX_W-1:0] w_hit_idx;
    logic             w_free_ok;
    logic [IDX_W-1:0] w_free_idx;

    // execute
    logic [ENT_W-1:0]            w_rdata;
    logic [ENT_W-1:0]            w_wdata;
    logic [FEATURE_BITS-1:0]     w_cur_bits;
    logic                        w_cur_direct;
    logic [BIND_COUNT_WIDTH-1:0] w_cur_binds;
    logic [FEATURE_BITS-1:0]     w_new_bits;
    logic                        w_new_direct;
    logic [BIND_COUNT_WIDTH-1:0] w_new_binds;
    logic [FEATURE_BITS-1:0]     w_old_f;
    logic [FEATURE_BITS-1:0]     w_new_f;
    logic                        w_inserted;
    logic                        w_null;
    logic [IDX_W-1:0]            w_idx;
    logic                        w_wr;
    t_cam_upd                    w_cam;
    t_status                     w_status;
    logic [FEATURE_BITS-1:0]     w_held;
    logic [FEATURE_BITS-1:0]     w_held_next;

    // output register
    logic                r_out_valid;
    logic [FEAT_W-1:0]   r_out_union;
    logic                r_out_changed;
    t_status             r_out_status;

    // ---------------------------------------------------------------
    // control state machine
    // ---------------------------------------------------------------
    assign w_accept = i_cmd.valid && i_cmd.ready;
    // execute only when the output register is free or being emptied
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_cmd.ready = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // lookup: id search and entry read in the accept cycle
    // ---------------------------------------------------------------
    assign w_key = i_cmd.source_id[KEY_W-1:0];

    rfmt_id_cam #(
        .MAX_SOURCES (MAX_SOURCES),
        .KEY_W       (KEY_W)
    ) u_id_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (w_key),
        .o_hit      (w_hit),
        .o_hit_idx  (w_hit_idx),
        .o_free_ok  (w_free_ok),
        .o_free_idx (w_free_idx),
        .i_upd      (w_cam),
        .i_upd_idx  (w_idx),
        .i_upd_key  (r_id)
    );

    rfmt_entry_ram #(
        .DEPTH (MAX_SOURCES),
        .WIDTH (ENT_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_hit_idx),
        .o_rdata (w_rdata)
    );

    // command capture: payload and lookup results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_cmd.cmd;
            r_id       <= w_key;
            r_bits     <= i_cmd.feature_bits_in[FEATURE_BITS-1:0];
            r_hit      <= w_hit;
            r_hit_idx  <= w_hit_idx;
            r_free_ok  <= w_free_ok;
            r_free_idx <= w_free_idx;
        end
    end

    // ---------------------------------------------------------------
    // execute: decide, write back entry, update id table and counters
    // ---------------------------------------------------------------
    assign w_null = (r_id == '0) || (r_cmd > CMD_REMOVE);

    always_comb begin
        w_cur_bits   = '0;
        w_cur_direct = 1'b0;
        w_cur_binds  = '0;
        // a new entry starts from zero, only a found one is read
        if (r_hit) begin
            {w_cur_bits, w_cur_direct, w_cur_binds} = w_rdata;
        end
        w_old_f      = (w_cur_direct || (w_cur_binds != '0)) ? w_cur_bits : '0;
        w_new_bits   = w_cur_bits;
        w_new_direct = w_cur_direct;
        w_new_binds  = w_cur_binds;
        w_new_f      = w_old_f;
        w_status     = ST_APPLIED;
        w_inserted   = 1'b0;
        w_idx        = r_hit_idx;
        w_wr         = 1'b0;
        w_cam        = '0;

        priority if (w_null) begin
            w_status = ST_NOOP;
        end else if (!r_hit && (r_cmd <= CMD_BIND) && !r_free_ok) begin
            w_status = ST_FULL;
        end else if (!r_hit && (r_cmd > CMD_BIND)) begin
            w_status = ST_NOT_FOUND;
        end else begin
            w_inserted = !r_hit;
            if (!r_hit) begin
                w_idx = r_free_idx;
            end
            unique case (t_cmd'(r_cmd))
                CMD_SET_DIRECT: begin
                    if (!w_inserted && w_cur_direct && (w_cur_bits == r_bits)) begin
                        w_status = ST_NOOP;
                    end else begin
                        w_new_bits   = r_bits;
                        w_new_direct = 1'b1;
                    end
                end
                CMD_UPDATE: begin
                    if (!w_inserted && (w_cur_bits == r_bits)) begin
                        w_status = ST_NOOP;
                    end else begin
                        w_new_bits = r_bits;
                    end
                end
                CMD_BIND: begin
                    // an existing entry keeps its own mask
                    if (w_inserted) begin
                        w_new_bits = r_bits;
                    end
                    if (&w_cur_binds) begin
                        w_status = ST_NOOP;
                    end else begin
                        w_new_binds = w_cur_binds + BIND_COUNT_WIDTH'(1);
                    end
                end
                CMD_UNBIND: begin
                    if (w_cur_binds == '0) begin
                        w_status = ST_NOOP;
                    end else begin
                        w_new_binds = w_cur_binds - BIND_COUNT_WIDTH'(1);
                    end
                end
                CMD_REMOVE: begin
                    w_cam.remove = 1'b1;
                end
                default: w_status = ST_NOOP;
            endcase

            if (w_status == ST_APPLIED) begin
                if (w_cam.remove) begin
                    w_new_f = '0;
                end else begin
                    w_wr         = 1'b1;
                    w_cam.insert = w_inserted;
                    w_new_f      = (w_new_direct || (w_new_binds != '0)) ? w_new_bits : '0;
                end
            end else begin
                w_cam.remove = 1'b0;
            end
        end

        // nothing reaches the stores outside the execute cycle
        if (!w_commit) begin
            w_wr  = 1'b0;
            w_cam = '0;
        end
    end

    assign w_wdata = {w_new_bits, w_new_direct, w_new_binds};

    rfmt_bit_users #(
        .FEATURE_BITS (FEATURE_BITS),
        .CNT_W        (CNT_W)
    ) u_bit_users (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_commit && (w_status == ST_APPLIED)),
        .i_removed   (w_old_f & ~w_new_f),
        .i_added     (w_new_f & ~w_old_f),
        .o_held      (w_held),
        .o_held_next (w_held_next)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_union   <= FEAT_W'(w_held_next);
            r_out_changed <= (w_held_next != w_held);
            r_out_status  <= w_status;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.union_mask   = r_out_union;
    assign o_res.mask_changed = r_out_changed;
    assign o_res.status       = r_out_status;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // only an applied command can move the union mask
    a_change_only_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_changed) |-> (r_out_status == ST_APPLIED))
        else $error("mask change reported on a command that was not applied");

    // a waiting result always matches the held union
    a_union_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_union == FEAT_W'(w_held)))
        else $error("result union differs from held mask");

    // not found comes only from unbind or remove
    a_not_found_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (w_status == ST_NOT_FOUND)) |->
            ((r_cmd == CMD_UNBIND) || (r_cmd == CMD_REMOVE)))
        else $error("not found on a command that allocates");

    // an allocation never targets an id that is already present
    a_insert_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_cam.insert) |-> (!r_hit && r_free_ok))
        else $error("entry allocated for an id already in the table");

endmodule

>>> dv/refcounted_feature_mask_table_checker.sv
`timescale 1ns / 100ps
// checker for the reference-counted feature mask table: watches both channels,
// predicts each result from its own copy of the source table and compares
// depends on rfmt_pkg and the channel interfaces in rfmt_if
module refcounted_feature_mask_table_checker #(
    parameter int MAX_SOURCES      = 32,
    parameter int FEATURE_BITS     = 64,
    parameter int ID_WIDTH         = 16,
    parameter int BIND_COUNT_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rfmt_cmd_if  i_cmd,
    rfmt_res_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import rfmt_pkg::*;

    localparam logic [FEAT_W-1:0] FEAT_KEEP =
        (FEATURE_BITS >= FEAT_W) ? {FEAT_W{1'b1}} : ((FEAT_W'(1) << FEATURE_BITS) - 1);
    localparam logic [SRC_ID_W-1:0] ID_KEEP =
        (ID_WIDTH >= SRC_ID_W) ? {SRC_ID_W{1'b1}} : ((SRC_ID_W'(1) << ID_WIDTH) - 1);
    localparam longint unsigned BIND_MAX = (longint'(1) << BIND_COUNT_WIDTH) - 1;

    typedef struct {
        logic [FEAT_W-1:0] union_mask;
        logic              mask_changed;
        t_status           status;
    } t_mask_result;

    // predicted source table
    bit                   slot_used   [MAX_SOURCES];
    logic [SRC_ID_W-1:0]  slot_id     [MAX_SOURCES];
    logic [FEAT_W-1:0]    slot_mask   [MAX_SOURCES];
    bit                   slot_direct [MAX_SOURCES];
    longint unsigned      slot_binds  [MAX_SOURCES];
    int unsigned          bit_users   [FEAT_W];
    logic [FEAT_W-1:0]    union_now;

    t_mask_result pending_results[$];

    function automatic int find_slot(logic [SRC_ID_W-1:0] id);
        for (int i = 0; i < MAX_SOURCES; i++)
            if (slot_used[i] && slot_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < MAX_SOURCES; i++)
            if (!slot_used[i]) return i;
        return -1;
    endfunction

    function automatic logic [FEAT_W-1:0] live_mask(int s);
        return (slot_direct[s] || slot_binds[s] != 0) ? slot_mask[s] : '0;
    endfunction

    function automatic void move_users(logic [FEAT_W-1:0] old_f, logic [FEAT_W-1:0] new_f);
        logic [FEAT_W-1:0] dropped;
        logic [FEAT_W-1:0] gained;
        dropped = old_f & ~new_f;
        gained  = new_f & ~old_f;
        for (int b = 0; b < FEAT_W; b++) begin
            if (dropped[b] && bit_users[b] != 0) begin
                bit_users[b]--;
                if (bit_users[b] == 0) union_now[b] = 1'b0;
            end
            if (gained[b]) begin
                union_now[b] = 1'b1;
                bit_users[b]++;
            end
        end
    endfunction

    function automatic t_mask_result predict_command(logic [CMD_W-1:0] op,
                                                     logic [SRC_ID_W-1:0] raw_id,
                                                     logic [FEAT_W-1:0] raw_bits);
        t_mask_result      r;
        logic [SRC_ID_W-1:0] id;
        logic [FEAT_W-1:0] bits;
        logic [FEAT_W-1:0] prior;
        logic [FEAT_W-1:0] old_f;
        int                s;
        bit                fresh;
        id       = raw_id & ID_KEEP;
        bits     = raw_bits & FEAT_KEEP;
        prior    = union_now;
        r.status = ST_APPLIED;
        fresh    = 1'b0;
        s        = -1;
        if (id == '0 || op > CMD_REMOVE) begin
            r.status = ST_NOOP;
        end else begin
            s = find_slot(id);
            if (op <= CMD_BIND && s < 0) begin
                s = free_slot();
                if (s < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_used[s]   = 1'b1;
                    slot_id[s]     = id;
                    slot_mask[s]   = '0;
                    slot_direct[s] = 1'b0;
                    slot_binds[s]  = 0;
                    fresh          = 1'b1;
                end
            end
            if (r.status == ST_APPLIED && s < 0) r.status = ST_NOT_FOUND;
        end
        if (r.status == ST_APPLIED) begin
            old_f = live_mask(s);
            case (op)
                CMD_SET_DIRECT: begin
                    if (!fresh && slot_direct[s] && slot_mask[s] == bits) begin
                        r.status = ST_NOOP;
                    end else begin
                        slot_mask[s]   = bits;
                        slot_direct[s] = 1'b1;
                    end
                end
                CMD_UPDATE: begin
                    if (!fresh && slot_mask[s] == bits) r.status = ST_NOOP;
                    else slot_mask[s] = bits;
                end
                CMD_BIND: begin
                    if (fresh) slot_mask[s] = bits;
                    if (slot_binds[s] >= BIND_MAX) r.status = ST_NOOP;
                    else slot_binds[s]++;
                end
                CMD_UNBIND: begin
                    if (slot_binds[s] == 0) r.status = ST_NOOP;
                    else slot_binds[s]--;
                end
                default: slot_used[s] = 1'b0;
            endcase
            if (r.status == ST_APPLIED)
                move_users(old_f, (op == CMD_REMOVE) ? '0 : live_mask(s));
        end
        r.union_mask   = union_now;
        r.mask_changed = (union_now != prior);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_mask_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SOURCES; i++) slot_used[i] = 1'b0;
            for (int b = 0; b < FEAT_W; b++) bit_users[b] = 0;
            union_now = '0;
            pending_results.delete();
            o_fail_count = 0;
        end else begin
            // the result of the command in flight leaves before the next one is scored
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: union_mask %h status %0d",
                           i_res.union_mask, i_res.status);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.union_mask !== want.union_mask) begin
                        $error("union_mask expected %h got %h", want.union_mask,
                               i_res.union_mask);
                        o_fail_count++;
                    end
                    if (i_res.mask_changed !== want.mask_changed) begin
                        $error("mask_changed expected %0b got %0b", want.mask_changed,
                               i_res.mask_changed);
                        o_fail_count++;
                    end
                    if (i_res.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_res.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                pending_results.push_back(predict_command(i_cmd.cmd, i_cmd.source_id,
                                                          i_cmd.feature_bits_in));
        end
        o_pending = pending_results.size();
    end

endmodule

>>> dv/refcounted_feature_mask_table_tb.sv
`timescale 1ns / 100ps
// top of the testbench for the reference-counted feature mask table: clock,
// reset, command stimulus, result back-pressure and the final verdict
// depends on rfmt_pkg, rfmt_if, the block and refcounted_feature_mask_table_checker
module refcounted_feature_mask_table_tb;
    import rfmt_pkg::*;

    localparam int MAX_SOURCES      = 32;
    localparam int FEATURE_BITS     = 64;
    localparam int ID_WIDTH         = 16;
    localparam int BIND_COUNT_WIDTH = 16;

    localparam int          RESET_CYCLES    = 8;
    localparam int unsigned LIMIT_CYCLES    = 1_000_000;
    localparam int          TAIL_CYCLES     = 10;
    localparam int          HOLD_CYCLES     = 120;
    localparam int          ITEMS_PER_PHASE = 340;
    localparam int          ID_POOL         = 40;
    localparam int          MASK_POOL       = 8;
    localparam int          BIND_REPEAT     = 6;

    // fixed ids for the directed part
    localparam logic [SRC_ID_W-1:0] ID_NULL   = '0;
    localparam logic [SRC_ID_W-1:0] ID_TOP    = 16'hFFFF;
    localparam logic [SRC_ID_W-1:0] ID_LOW    = 16'h0001;
    localparam logic [SRC_ID_W-1:0] ID_HIGH   = 16'h8000;
    localparam logic [SRC_ID_W-1:0] ID_ABSENT = 16'h1234;
    localparam logic [SRC_ID_W-1:0] ID_EXTRA  = 16'h7777;
    localparam logic [SRC_ID_W-1:0] ID_FILL   = 16'h4000;
    localparam logic [SRC_ID_W-1:0] ID_SAT    = 16'h00F0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rfmt_cmd_if cmd_ch ();
    rfmt_res_if res_ch ();

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          hold_flip     = 1'b0;
    bit          hold_seen     = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    logic [SRC_ID_W-1:0] id_pool   [ID_POOL];
    logic [FEAT_W-1:0]   mask_pool [MASK_POOL];

    always #5 clk = ~clk;

    refcounted_feature_mask_table #(
        .MAX_SOURCES      (MAX_SOURCES),
        .FEATURE_BITS     (FEATURE_BITS),
        .ID_WIDTH         (ID_WIDTH),
        .BIND_COUNT_WIDTH (BIND_COUNT_WIDTH)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    refcounted_feature_mask_table_checker #(
        .MAX_SOURCES      (MAX_SOURCES),
        .FEATURE_BITS     (FEATURE_BITS),
        .ID_WIDTH         (ID_WIDTH),
        .BIND_COUNT_WIDTH (BIND_COUNT_WIDTH)
    ) mask_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog against a hung handshake
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("refcounted_feature_mask_table test failed");
            $finish;
        end
    end

    // result back-pressure: random stalls, or a long hold-off when the
    // stimulus flips hold_flip; the hold length is counted here
    initial res_ch.ready = 1'b0;
    always @(negedge clk) begin
        if (hold_flip != hold_seen) begin
            hold_seen    <= hold_flip;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one command transaction: optional idle gap, then hold valid until taken;
    // returns on the falling edge after acceptance with valid still high
    task automatic send_command(logic [CMD_W-1:0] op, logic [SRC_ID_W-1:0] id,
                                logic [FEAT_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid           = 1'b1;
        cmd_ch.cmd             = op;
        cmd_ch.source_id       = id;
        cmd_ch.feature_bits_in = bits;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and let every predicted result come back
    task automatic wait_drained();
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // few set bits, so counters see overlap and partial withdrawals
    function automatic logic [FEAT_W-1:0] sparse_mask();
        return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endfunction

    function automatic logic [FEAT_W-1:0] pick_mask();
        int r;
        r = $urandom_range(99);
        if (r < 60) return mask_pool[$urandom_range(MASK_POOL - 1)];
        if (r < 85) return sparse_mask();
        return {$urandom, $urandom};
    endfunction

    // mostly well-formed commands on a small id pool larger than the table,
    // so entries get reused, the table fills and lookups miss; some noise
    task automatic send_random_item();
        int                  r;
        logic [CMD_W-1:0]    op;
        logic [SRC_ID_W-1:0] id;
        r = $urandom_range(99);
        if (r < 20)      op = CMD_SET_DIRECT;
        else if (r < 35) op = CMD_UPDATE;
        else if (r < 60) op = CMD_BIND;
        else if (r < 80) op = CMD_UNBIND;
        else if (r < 96) op = CMD_REMOVE;
        else             op = CMD_REMOVE + CMD_W'($urandom_range(1, 3));
        r = $urandom_range(99);
        if (r < 3)      id = ID_NULL;
        else if (r < 8) id = SRC_ID_W'($urandom);
        else            id = id_pool[$urandom_range(ID_POOL - 1)];
        send_command(op, id, pick_mask());
    endtask

    initial begin
        int idle_tbl  [4];
        int stall_tbl [4];
        idle_tbl  = '{0, 58, 0, 31};
        stall_tbl = '{0, 0, 58, 31};

        cmd_ch.valid           = 1'b0;
        cmd_ch.cmd             = CMD_SET_DIRECT;
        cmd_ch.source_id       = ID_NULL;
        cmd_ch.feature_bits_in = '0;
        for (int i = 0; i < ID_POOL; i++) id_pool[i] = SRC_ID_W'($urandom_range(1, 16'hFFFF));
        for (int i = 0; i < MASK_POOL; i++) mask_pool[i] = sparse_mask();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and every command kind
        send_command(CMD_SET_DIRECT, ID_TOP, '1);                 // all bits appear
        send_command(CMD_SET_DIRECT, ID_TOP, '1);                 // same mask, no-op
        send_command(CMD_UPDATE, ID_TOP, '0);                     // direct source clears
        send_command(CMD_UPDATE, ID_TOP, '0);                     // equal mask, no-op
        send_command(CMD_UPDATE, ID_LOW, 64'hAAAA_AAAA_AAAA_AAAA); // new, inactive
        send_command(CMD_BIND, ID_LOW, 64'h0123_4567_89AB_CDEF);   // own mask wins
        send_command(CMD_BIND, ID_HIGH, 64'h5555_5555_5555_5555);  // new via bind
        send_command(CMD_UNBIND, ID_HIGH, '0);                    // drops to inactive
        send_command(CMD_UNBIND, ID_HIGH, '1);                    // count zero, no-op
        send_command(CMD_UNBIND, ID_ABSENT, '0);                  // not found
        send_command(CMD_REMOVE, ID_ABSENT, '0);                  // not found
        send_command(CMD_REMOVE, ID_LOW, '0);                     // withdraws its bits
        send_command(CMD_SET_DIRECT, ID_NULL, '1);                // null id ignored
        send_command(CMD_BIND, ID_NULL, '1);
        for (int k = 1; k <= 3; k++)                              // unused command codes
            send_command(CMD_REMOVE + CMD_W'(k), ID_TOP, '1);
        send_command(CMD_REMOVE, ID_HIGH, '0);
        send_command(CMD_REMOVE, ID_TOP, '0);

        // table full: fill every slot, then try to add through each allocating command
        for (int i = 0; i < MAX_SOURCES; i++)
            send_command(CMD_SET_DIRECT, ID_FILL + SRC_ID_W'(i), sparse_mask());
        send_command(CMD_SET_DIRECT, ID_EXTRA, '1);
        send_command(CMD_UPDATE, ID_EXTRA, '1);
        send_command(CMD_BIND, ID_EXTRA, '1);
        send_command(CMD_UNBIND, ID_EXTRA, '1);
        send_command(CMD_REMOVE, ID_FILL + SRC_ID_W'(5), '0);
        send_command(CMD_SET_DIRECT, ID_EXTRA, sparse_mask());    // takes the freed slot
        for (int i = 0; i < MAX_SOURCES; i++)
            send_command(CMD_REMOVE, ID_FILL + SRC_ID_W'(i), '0);
        send_command(CMD_REMOVE, ID_EXTRA, '0);
        wait_drained();

        // repeated binds and unbinds on one source, run back to back
        for (int n = 0; n < BIND_REPEAT; n++)
            send_command(CMD_BIND, ID_SAT, {$urandom, $urandom});
        for (int n = 0; n <= BIND_REPEAT; n++)
            send_command(CMD_UNBIND, ID_SAT, '0);                 // last one is a no-op
        send_command(CMD_BIND, ID_SAT, '0);
        send_command(CMD_REMOVE, ID_SAT, '0);
        wait_drained();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tbl[ph];
            stall_pct <= stall_tbl[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 100 == 0)
                    for (int i = 0; i < MASK_POOL; i++) mask_pool[i] = sparse_mask();
                // long result hold-off while commands keep coming, so the block backs up
                if ((ph == 0 && n == 120) || (ph == 3 && n == 200))
                    hold_flip <= ~hold_flip;
                // sender pause until everything has come back
                if ((ph == 2 && n == 150) || (ph == 3 && n == 60))
                    wait_drained();
                send_random_item();
            end
            wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("refcounted_feature_mask_table test passed");
        end else begin
            $display("refcounted_feature_mask_table test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rfmt_pkg.sv
rtl/rfmt_if.sv
rtl/rfmt_id_cam.sv
rtl/rfmt_entry_ram.sv
rtl/rfmt_bit_users.sv
rtl/refcounted_feature_mask_table.sv
dv/refcounted_feature_mask_table_checker.sv
dv/refcounted_feature_mask_table_tb.sv
